@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and codes for the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PRI_W       = 16;
  localparam int DATA_W      = 32;
  localparam int OPC_W       = 2;
  localparam int STAT_W      = 2;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OPC_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OPC_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLR = 2'd2;
  localparam logic [OPC_W-1:0] OP_NOP = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]         opcode;
    logic [PRI_W-1:0]         new_priority;
    logic signed [DATA_W-1:0] new_data;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_data;
    logic [PRI_W-1:0]         out_priority;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       entry_count;
  } out_t;

  typedef struct packed {
    logic [PRI_W-1:0]         pri;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
    logic clr;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept sorted by ascending priority number in a row of cells.
// ----------------------------------------------------------------------------
// Output: the result appears on out_result with out_strobe in the cycle after
// the transaction is accepted.
// Throughput: one transaction per cycle; every cell updates in parallel from
// its neighbors, so busy stays low and the receiver cannot stall.
// Reset: synchronous, active low; empties the queue, stored words are left.
module sorted_priority_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::in_t  in_item,
  output logic          out_strobe,
  output spq_pkg::out_t out_result
);

  localparam int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH;
  localparam int CNT_W = spq_pkg::COUNT_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  spq_pkg::entry_t    cell_entry [QUEUE_DEPTH];
  logic               cell_valid [QUEUE_DEPTH];
  logic               cell_disp  [QUEUE_DEPTH];
  spq_pkg::entry_t    new_entry;
  spq_pkg::cell_ctrl_t ctrl;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_strobe_r;
  spq_pkg::out_t      out_result_r, out_result_nxt;
  logic               accept, is_full, is_empty;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = count_r == FULL_CNT;
  assign is_empty = count_r == '0;

  assign new_entry.pri  = in_item.new_priority;
  assign new_entry.data = in_item.new_data;

  assign ctrl.enq = accept && (in_item.opcode == spq_pkg::OP_ENQ) && !is_full;
  assign ctrl.deq = accept && (in_item.opcode == spq_pkg::OP_DEQ) && !is_empty;
  assign ctrl.clr = accept && (in_item.opcode == spq_pkg::OP_CLR);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_entry, right_entry;
    logic            left_valid, left_disp, right_valid;

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_valid = 1'b1;
      assign left_disp  = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_disp  = cell_disp[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
      assign right_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .cmp_strict  (i == 0),
      .left_entry  (left_entry),
      .left_valid  (left_valid),
      .left_disp   (left_disp),
      .right_entry (right_entry),
      .right_valid (right_valid),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .disp        (cell_disp[i])
    );
  end

  always_comb begin
    count_nxt      = count_r;
    out_result_nxt = '0;
    if (ctrl.clr) begin
      count_nxt = '0;
    end else if (ctrl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_nxt                   = count_r - CNT_W'(1);
      out_result_nxt.out_data     = cell_entry[0].data;
      out_result_nxt.out_priority = cell_entry[0].pri;
    end

    if (in_item.opcode == spq_pkg::OP_ENQ && is_full) begin
      out_result_nxt.status = spq_pkg::ST_OVER;
    end else if (in_item.opcode == spq_pkg::OP_DEQ && is_empty) begin
      out_result_nxt.status = spq_pkg::ST_UNDER;
    end else begin
      out_result_nxt.status = spq_pkg::ST_OK;
    end
    out_result_nxt.entry_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      out_strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_result_r <= out_result_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

endmodule

@@ hw/rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; shifts toward the tail on insert and toward the head on
// removal, deciding locally from its own compare and its left neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t   new_entry,
  input  logic              cmp_strict,
  input  spq_pkg::entry_t   left_entry,
  input  logic              left_valid,
  input  logic              left_disp,
  input  spq_pkg::entry_t   right_entry,
  input  logic              right_valid,
  output spq_pkg::entry_t   entry,
  output logic              valid,
  output logic              disp
);

  spq_pkg::entry_t entry_r, entry_nxt;
  logic            valid_r, valid_nxt;
  logic            pri_gt, pri_eq;

  assign pri_gt = entry_r.pri > new_entry.pri;
  assign pri_eq = entry_r.pri == new_entry.pri;

  // An empty cell counts as displaced so the new entry lands at the tail.
  // The head cell only yields to a strictly smaller priority number.
  assign disp = !valid_r || pri_gt || (!cmp_strict && pri_eq);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.enq) begin
      if (disp) begin
        entry_nxt = left_disp ? left_entry : new_entry;
        valid_nxt = left_valid;
      end
    end else if (ctrl.deq) begin
      entry_nxt = right_entry;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

@@ tb/sv/sorted_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives enqueue, dequeue, clear and unused commands into the queue and
// checks every result against a sorted-array model of the queue kept here.
// A directed opening covers the empty and full edges, priority ties with the
// head and tail, and the field extremes. Random traffic follows in phases
// with different amounts of sender idling.
// ----------------------------------------------------------------------------

class sorted_queue_scoreboard;
  logic [spq_pkg::PRI_W-1:0]         pri_mem [spq_pkg::QUEUE_DEPTH];
  logic signed [spq_pkg::DATA_W-1:0] data_mem[spq_pkg::QUEUE_DEPTH];
  int                                fill;
  spq_pkg::out_t                     expected_results[$];
  int                                errors;

  function new();
    fill   = 0;
    errors = 0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Applies one command to the queue image and returns the result it causes.
  function spq_pkg::out_t apply_command(spq_pkg::in_t cmd);
    spq_pkg::out_t res;
    int            slot;
    res = '0;
    case (cmd.opcode)
      spq_pkg::OP_ENQ: begin
        if (fill >= spq_pkg::QUEUE_DEPTH) begin
          res.status = spq_pkg::ST_OVER;
        end else begin
          // A tie with the head lands behind it; later ties go in front.
          if (fill == 0 || pri_mem[0] > cmd.new_priority) begin
            slot = 0;
          end else begin
            slot = 1;
            while (slot < fill && pri_mem[slot] < cmd.new_priority) slot++;
          end
          for (int i = fill; i > slot; i--) begin
            pri_mem[i]  = pri_mem[i-1];
            data_mem[i] = data_mem[i-1];
          end
          pri_mem[slot]  = cmd.new_priority;
          data_mem[slot] = cmd.new_data;
          fill++;
        end
      end
      spq_pkg::OP_DEQ: begin
        if (fill == 0) begin
          res.status = spq_pkg::ST_UNDER;
        end else begin
          res.out_data     = data_mem[0];
          res.out_priority = pri_mem[0];
          for (int i = 1; i < fill; i++) begin
            pri_mem[i-1]  = pri_mem[i];
            data_mem[i-1] = data_mem[i];
          end
          fill--;
        end
      end
      spq_pkg::OP_CLR: begin
        fill = 0;
      end
      default: begin
      end
    endcase
    res.entry_count = spq_pkg::COUNT_W'(fill);
    return res;
  endfunction

  function void note_command(spq_pkg::in_t cmd);
    expected_results.push_back(apply_command(cmd));
  endfunction

  task check_result(spq_pkg::out_t got);
    spq_pkg::out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", 64'(got), 64'd0);
    end else begin
      want = expected_results.pop_front();
      if (got.out_data !== want.out_data)
        report_mismatch("out_data", 64'(got.out_data), 64'(want.out_data));
      if (got.out_priority !== want.out_priority)
        report_mismatch("out_priority", 64'(got.out_priority), 64'(want.out_priority));
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.entry_count !== want.entry_count)
        report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
    end
  endtask
endclass

module sorted_priority_queue_tb;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 270;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          start;
  logic          busy;
  spq_pkg::in_t  in_item;
  logic          out_strobe;
  spq_pkg::out_t out_result;

  sorted_queue_scoreboard sb = new();
  int                     cycles = 0;

  sorted_priority_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Values sampled here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_command(in_item);
      if (out_strobe) sb.check_result(out_result);
    end
  end

  // Idles with start low when gap is positive, then holds the command until it is taken.
  task send_command(logic [spq_pkg::OPC_W-1:0] op, logic [spq_pkg::PRI_W-1:0] pri,
                    logic signed [spq_pkg::DATA_W-1:0] dat, int gap);
    spq_pkg::in_t cmd;
    cmd.opcode       = op;
    cmd.new_priority = pri;
    cmd.new_data     = dat;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy);
  endtask

  // Lowers start, then lets the monitor log the last accepted transaction before waiting for every pending result.
  task drain_queue();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task run_directed();
    send_command(spq_pkg::OP_DEQ, 16'h1234, 32'sh5A5A5A5A, 0);
    send_command(spq_pkg::OP_CLR, 16'hFFFF, -32'sd1, 0);
    send_command(spq_pkg::OP_NOP, 16'h0000, 32'sd0, 0);
    send_command(spq_pkg::OP_ENQ, 16'hFFFF, 32'sh7FFFFFFF, 0);
    send_command(spq_pkg::OP_ENQ, 16'h0000, 32'sh80000000, 0);
    send_command(spq_pkg::OP_ENQ, 16'h0000, 32'sd1, 0);
    send_command(spq_pkg::OP_ENQ, 16'hFFFF, -32'sd1, 0);
    send_command(spq_pkg::OP_ENQ, 16'h0000, 32'sd2, 0);
    for (int i = 0; i < 12; i++)
      send_command(spq_pkg::OP_ENQ, 16'(i % 3 + 5), spq_pkg::DATA_W'(i + 100), 0);
    send_command(spq_pkg::OP_ENQ, 16'h0001, 32'sd999, 0);
    send_command(spq_pkg::OP_NOP, 16'hFFFF, -32'sd1, 0);
    send_command(spq_pkg::OP_DEQ, 16'h0000, 32'sd0, 0);
    send_command(spq_pkg::OP_CLR, 16'h0000, 32'sd0, 0);
    send_command(spq_pkg::OP_DEQ, 16'h0000, 32'sd0, 0);
  endtask

  function logic [spq_pkg::PRI_W-1:0] pick_priority();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return spq_pkg::PRI_W'($urandom_range(0, 7));
    if (sel < 55) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return spq_pkg::PRI_W'($urandom());
  endfunction

  task run_random(int items, int idle_pct);
    int   mode;
    int   roll;
    int   gap;
    int   quiet;
    logic [spq_pkg::OPC_W-1:0] op;
    for (int n = 0; n < items; n++) begin
      // Each burst leans toward filling or emptying, or stays balanced, so both edges are reached.
      if (n % 20 == 0) begin
        mode  = $urandom_range(0, 2);
        quiet = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 2)      op = spq_pkg::OP_CLR;
      else if (roll < 4) op = spq_pkg::OP_NOP;
      else if (mode == 0) op = (roll < 82) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
      else if (mode == 1) op = (roll < 82) ? spq_pkg::OP_DEQ : spq_pkg::OP_ENQ;
      else               op = (roll < 52) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 4);
      send_command(op, pick_priority(), spq_pkg::DATA_W'($urandom()), gap);
    end
  endtask

  initial begin
    int idle_plan[6];
    idle_plan = '{0, 59, 21, 0, 59, 21};
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain_queue();
    foreach (idle_plan[p]) begin
      run_random(PHASE_ITEMS, idle_plan[p]);
      // After every second phase, hold off until every outstanding transaction has come back.
      if (p % 2 == 1) drain_queue();
    end
    drain_queue();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_tb.sv
